>>> design/bdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants of the binary disk morphology unit.
// ----------------------------------------------------------------------------
package bdm_pkg;

  // Default sizes of the mark grid and the largest disk radius in cells
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_RADIUS = 15;

  // Item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Register indexes
  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 9;
  localparam logic [2:0]  REG_ROWS   = 3'd0;
  localparam logic [2:0]  REG_COLS   = 3'd1;
  localparam logic [2:0]  REG_RADIUS = 3'd2;
  localparam logic [2:0]  REG_GROW   = 3'd3;

  // Register reset values
  localparam logic [6:0] RST_ROWS   = 7'd64;
  localparam logic [6:0] RST_COLS   = 7'd64;
  localparam logic [8:0] RST_RADIUS = 9'd16;
  localparam logic       RST_GROW   = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       mark_in;
  } bdm_in_t;

  typedef struct packed {
    logic mark_out;
    logic status;
  } bdm_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;     // clear one mark entry, advance the clear counter
    logic item_acc;     // transaction accepted on the input channel
    logic out_mem;      // post the registered mark read as a result
    logic out_run;      // post the result of a finished run
    logic run_start;    // latch mode and radius, rewind the cell counters
    logic snap_mark_rd; // read the mark at the current cell
    logic snap_wr;      // write the snapshot bit of the current cell
    logic cell_rd;      // read the snapshot at the current cell, rewind the disk walk
    logic cell_adv;     // step to the next cell, wrapping at the end
    logic disk_rd;      // read the snapshot at the current disk corner
    logic q_adv;        // next corner
    logic j_adv;        // next column offset
    logic i_adv;        // next row offset
    logic hit_wr;       // write the mode into the mark of the current cell
  } bdm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic kind_run;
    logic read_hit;
    logic clr_last;
    logic cell_last;
    logic run_skip;
    logic snap_bit;
    logic in_disk;
    logic q_last;
    logic i_last;
  } bdm_stat_t;

endpackage

>>> design/binary_disk_morphology_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_disk_morphology_unit
// Binary mark grid with cell load and read and a disk dilate or erode run.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries load, run and read items; every
//   item yields exactly one result transaction on out_valid/out_ready.
//   Configuration goes through cfg_we/cfg_index/cfg_data, taken at any edge
//   with cfg_we high; write it only while the unit is idle.
//   Load, unknown kind and out-of-grid items: the result is in the output
//   register after the accepting edge; the next item can follow in the
//   next cycle when the output register is free or being taken.
//   In-grid read: a registered read of the mark memory, then the output register.
//   Run: a snapshot pass writes the mark of each used cell, xored with
//   the mode, to the snapshot memory; a cell pass then reads each
//   snapshot bit and, for each set one, reads the corners of each in-disk
//   offset through the single read port of the snapshot memory.
//   Reset: a clearing pass over all MAX_ROWS*MAX_COLS entries (4096 by default)
//   zeroes the mark memory; no item is accepted meanwhile.
//   A stalled output holds its result; in_ready stays low until the
//   output register is free or being taken.
// ----------------------------------------------------------------------------
module binary_disk_morphology_unit import bdm_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bdm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bdm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bdm_cmd_t  cmd;
  bdm_stat_t stat;

  // Sequencer
  bdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  bdm_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> design/bdm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_ctrl
// Sequencer of the morphology unit: clearing pass, item handling and the
// snapshot and disk walks of a run.
// ----------------------------------------------------------------------------
module bdm_ctrl import bdm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bdm_stat_t stat,
  output bdm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDOUT, S_SNAP_RD, S_SNAP_WR, S_CELL_RD, S_CELL_CHK,
    S_DISK_TEST, S_DISK_CHK, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.item_acc = 1'b1;
          if (stat.kind_run) begin
            cmd.run_start = 1'b1;
            state_next    = S_SNAP_RD;
          end else if (stat.read_hit) begin
            state_next = S_RDOUT;
          end
        end
      end
      S_RDOUT: begin
        cmd.out_mem = 1'b1;
        state_next  = S_IDLE;
      end
      S_SNAP_RD: begin
        cmd.snap_mark_rd = 1'b1;
        state_next       = S_SNAP_WR;
      end
      S_SNAP_WR: begin
        cmd.snap_wr  = 1'b1;
        cmd.cell_adv = 1'b1;
        if (!stat.cell_last) state_next = S_SNAP_RD;
        else if (stat.run_skip) state_next = S_DONE;
        else state_next = S_CELL_RD;
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_CELL_CHK;
      end
      S_CELL_CHK: begin
        if (stat.snap_bit) begin
          state_next = S_DISK_TEST;
        end else begin
          cmd.cell_adv = 1'b1;
          state_next   = stat.cell_last ? S_DONE : S_CELL_RD;
        end
      end
      S_DISK_TEST: begin
        if (stat.in_disk) begin
          cmd.disk_rd = 1'b1;
          state_next  = S_DISK_CHK;
        end else if (stat.i_last) begin
          cmd.cell_adv = 1'b1;
          state_next   = stat.cell_last ? S_DONE : S_CELL_RD;
        end else begin
          cmd.i_adv = 1'b1;
        end
      end
      S_DISK_CHK: begin
        if (!stat.snap_bit) begin
          cmd.hit_wr   = 1'b1;
          cmd.cell_adv = 1'b1;
          state_next   = stat.cell_last ? S_DONE : S_CELL_RD;
        end else if (stat.q_last) begin
          cmd.j_adv  = 1'b1;
          state_next = S_DISK_TEST;
        end else begin
          cmd.q_adv  = 1'b1;
          state_next = S_DISK_TEST;
        end
      end
      S_DONE: begin
        cmd.out_run = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

endmodule

>>> design/bdm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_datapath
// Registers, mark and snapshot memories, walk counters, disk test and the
// output register of the morphology unit.
// ----------------------------------------------------------------------------
module bdm_datapath import bdm_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bdm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bdm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bdm_cmd_t              cmd,
  output bdm_stat_t             stat
);

  localparam int RW      = $clog2(MAX_ROWS);
  localparam int CW      = $clog2(MAX_COLS);
  localparam int RCW     = $clog2(MAX_ROWS + 1);
  localparam int CCW     = $clog2(MAX_COLS + 1);
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int MAG_MAX = MAX_RADIUS * 16;
  localparam int MW      = $clog2(MAG_MAX + 1);
  localparam int DW      = $clog2(MAX_RADIUS + 2);

  logic [6:0] grid_rows, grid_cols;
  logic [8:0] radius_q;
  logic       grow_mode;

  logic [RCW-1:0] rows_u;
  logic [CCW-1:0] cols_u;
  logic [9:0]     abs_q;
  logic [MW-1:0]  mag_sat, mag;
  logic [2*MW-1:0] m2;
  logic           mode;
  logic [DW-1:0]  maxd;

  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [DW-1:0] i, j;
  logic [1:0]    q;
  logic [AW-1:0] clr_cnt;

  logic          mark_mem [DEPTH];
  logic          snap_mem [DEPTH];
  logic          mark_q, snap_q;
  logic [AW-1:0] in_addr, cur_addr, quad_addr, mark_raddr, snap_raddr;

  logic          in_ok, is_rw, row_last, col_last;
  logic [2*DW-1:0] ii, jj;
  int            ri0, ri1, ci0, ci1;
  logic [RW-1:0] qr;
  logic [CW-1:0] qc;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(row) * AW'(MAX_COLS) + AW'(col);
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= RST_ROWS;
      grid_cols <= RST_COLS;
      radius_q  <= RST_RADIUS;
      grow_mode <= RST_GROW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:   grid_rows <= cfg_data[6:0];
        REG_COLS:   grid_cols <= cfg_data[6:0];
        REG_RADIUS: radius_q  <= cfg_data;
        REG_GROW:   grow_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp grid size, take the radius magnitude and saturate it
  always_comb begin
    if (grid_rows == 7'd0) rows_u = RCW'(1);
    else if (32'(grid_rows) > MAX_ROWS) rows_u = RCW'(MAX_ROWS);
    else rows_u = RCW'(grid_rows);
    if (grid_cols == 7'd0) cols_u = CCW'(1);
    else if (32'(grid_cols) > MAX_COLS) cols_u = CCW'(MAX_COLS);
    else cols_u = CCW'(grid_cols);
    abs_q   = radius_q[8] ? (10'd0 - {radius_q[8], radius_q}) : {1'b0, radius_q};
    mag_sat = (32'(abs_q) > MAG_MAX) ? MW'(MAG_MAX) : MW'(abs_q);
  end

  // Latch run mode and radius; square the latched radius in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      mag  <= mag_sat;
      mode <= grow_mode ^ radius_q[8];
    end
    m2 <= mag * mag;
  end

  assign maxd = DW'(mag >> 4);

  // Input decode
  assign in_ok = (32'(in_data.cell_row) < 32'(rows_u)) &&
                 (32'(in_data.cell_col) < 32'(cols_u));
  assign is_rw = (in_data.kind == KIND_LOAD) || (in_data.kind == KIND_READ);
  assign in_addr = cell_addr(RW'(in_data.cell_row), CW'(in_data.cell_col));

  // Cell walk position
  assign row_last = (32'(r) == 32'(rows_u) - 1);
  assign col_last = (32'(c) == 32'(cols_u) - 1);
  assign cur_addr = cell_addr(r, c);

  // Clamped corners of the current disk offset
  always_comb begin
    ri0 = int'(r) - int'(i);
    if (ri0 < 0) ri0 = 0;
    ri1 = int'(r) + int'(i);
    if (ri1 > int'(rows_u) - 1) ri1 = int'(rows_u) - 1;
    ci0 = int'(c) - int'(j);
    if (ci0 < 0) ci0 = 0;
    ci1 = int'(c) + int'(j);
    if (ci1 > int'(cols_u) - 1) ci1 = int'(cols_u) - 1;
    qr = q[1] ? RW'(ri1) : RW'(ri0);
    qc = q[0] ? CW'(ci1) : CW'(ci0);
  end

  assign quad_addr = cell_addr(qr, qc);

  // Disk membership by comparison of squares
  assign ii = i * i;
  assign jj = j * j;

  // Walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
    if (cmd.run_start) begin
      r <= '0;
      c <= '0;
    end else if (cmd.cell_adv) begin
      if (col_last) begin
        c <= '0;
        r <= row_last ? '0 : r + RW'(1);
      end else begin
        c <= c + CW'(1);
      end
    end
    if (cmd.cell_rd) begin
      i <= '0;
      j <= '0;
      q <= '0;
    end else if (cmd.i_adv) begin
      i <= i + DW'(1);
      j <= '0;
      q <= '0;
    end else if (cmd.j_adv) begin
      j <= j + DW'(1);
      q <= '0;
    end else if (cmd.q_adv) begin
      q <= q + 2'd1;
    end
  end

  // Mark memory: one write port, one registered read port
  assign mark_raddr = cmd.snap_mark_rd ? cur_addr : in_addr;
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mark_mem[clr_cnt] <= 1'b0;
    else if (cmd.item_acc && in_data.kind == KIND_LOAD && in_ok)
      mark_mem[in_addr] <= in_data.mark_in;
    else if (cmd.hit_wr) mark_mem[cur_addr] <= mode;
    mark_q <= mark_mem[mark_raddr];
  end

  // Snapshot memory
  assign snap_raddr = cmd.disk_rd ? quad_addr : cur_addr;
  always_ff @(posedge clk) begin
    if (cmd.snap_wr) snap_mem[cur_addr] <= mark_q ^ mode;
    snap_q <= snap_mem[snap_raddr];
  end

  // Output register: load a new result, else drain on the taken transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.item_acc && !stat.kind_run && !stat.read_hit) begin
        out_valid         <= 1'b1;
        out_data.mark_out <= 1'b0;
        out_data.status   <= is_rw && !in_ok;
      end else if (cmd.out_mem) begin
        out_valid         <= 1'b1;
        out_data.mark_out <= mark_q;
        out_data.status   <= 1'b0;
      end else if (cmd.out_run) begin
        out_valid         <= 1'b1;
        out_data.mark_out <= 1'b0;
        out_data.status   <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    stat.out_free  = !out_valid || out_ready;
    stat.kind_run  = (in_data.kind == KIND_RUN);
    stat.read_hit  = (in_data.kind == KIND_READ) && in_ok;
    stat.clr_last  = (clr_cnt == AW'(DEPTH - 1));
    stat.cell_last = row_last && col_last;
    stat.run_skip  = (maxd == '0);
    stat.snap_bit  = snap_q;
    stat.in_disk   = ((32'(ii) + 32'(jj)) << 8) <= 32'(m2);
    stat.q_last    = (q == 2'd3);
    stat.i_last    = (i == maxd);
  end

endmodule

>>> verif/binary_disk_morphology_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_disk_morphology_unit_tb
// Self-checking bench for the mark grid: cell loads and reads, dilate and
// erode runs over a clamped disk, grid clamping and out-of-grid addresses.
// An internal grid model predicts every result. Stimulus runs through
// several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module binary_disk_morphology_unit_tb;
  import bdm_pkg::*;

  localparam int  GRID_MAX   = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int  RADIUS_SAT = DEF_MAX_RADIUS * 16;
  localparam int  CYCLE_CAP  = 40_000_000;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Grid model plus the queue of results still owed by the block
  class bdm_scoreboard;
    bit         marks [GRID_MAX];
    bit         snap  [GRID_MAX];
    bit   [6:0] rows_r;
    bit   [6:0] cols_r;
    bit   [8:0] radius_r;
    bit         grow_r;
    bdm_out_t   owed_q[$];
    int         errors;

    function new();
      foreach (marks[k]) marks[k] = 1'b0;
      foreach (snap[k]) snap[k] = 1'b0;
      rows_r   = RST_ROWS;
      cols_r   = RST_COLS;
      radius_r = RST_RADIUS;
      grow_r   = RST_GROW;
      errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] d);
      case (idx)
        REG_ROWS:   rows_r   = d[6:0];
        REG_COLS:   cols_r   = d[6:0];
        REG_RADIUS: radius_r = d;
        REG_GROW:   grow_r   = d[0];
        default: ;
      endcase
    endfunction

    function int clamp_size(bit [6:0] v, int lim);
      if (v < 1) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function bit snap_at(int r, int c);
      return snap[r * DEF_MAX_COLS + c];
    endfunction

    // Dilate or erode over the disk, all cells working from one snapshot
    function void run_disk();
      int rows, cols, mag, maxd, m2, r, c, i, j, r0, r1, c0, c1;
      bit neg, mode, hit;
      rows = clamp_size(rows_r, DEF_MAX_ROWS);
      cols = clamp_size(cols_r, DEF_MAX_COLS);
      neg  = radius_r[8];
      mag  = neg ? ((512 - int'(radius_r)) & 511) : int'(radius_r);
      mode = grow_r ^ neg;
      if (mag == 0 && neg) mag = 256;
      if (mag > RADIUS_SAT) mag = RADIUS_SAT;
      for (r = 0; r < rows; r++)
        for (c = 0; c < cols; c++)
          snap[r * DEF_MAX_COLS + c] = marks[r * DEF_MAX_COLS + c] ^ mode;
      maxd = mag >> 4;
      if (maxd < 1) return;
      m2 = mag * mag;
      for (r = 0; r < rows; r++)
        for (c = 0; c < cols; c++) begin
          if (!snap_at(r, c)) continue;
          hit = 1'b0;
          for (i = 0; i <= maxd && !hit; i++) begin
            r0 = (r - i < 0) ? 0 : r - i;
            r1 = (r + i > rows - 1) ? rows - 1 : r + i;
            for (j = 0; j <= maxd; j++) begin
              if (256 * (i * i + j * j) > m2) break;
              c0 = (c - j < 0) ? 0 : c - j;
              c1 = (c + j > cols - 1) ? cols - 1 : c + j;
              if (!(snap_at(r0, c0) && snap_at(r0, c1) &&
                    snap_at(r1, c0) && snap_at(r1, c1))) begin
                hit = 1'b1;
                break;
              end
            end
          end
          if (hit) marks[r * DEF_MAX_COLS + c] = mode;
        end
    endfunction

    // Apply one accepted input transaction and queue its result
    function void note_input(bdm_in_t it);
      bdm_out_t res;
      int k;
      res = '0;
      if (it.kind == KIND_RUN) begin
        run_disk();
      end else if (it.kind == KIND_LOAD || it.kind == KIND_READ) begin
        if (it.cell_row >= clamp_size(rows_r, DEF_MAX_ROWS) ||
            it.cell_col >= clamp_size(cols_r, DEF_MAX_COLS)) begin
          res.status = 1'b1;
        end else begin
          k = it.cell_row * DEF_MAX_COLS + it.cell_col;
          if (it.kind == KIND_LOAD) marks[k] = it.mark_in;
          else res.mark_out = marks[k];
        end
      end
      owed_q = {owed_q, res};
    endfunction

    function void check_result(bdm_out_t got);
      bdm_out_t want;
      if (owed_q.size() == 0) begin
        $error("result transaction with nothing expected: %b", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.mark_out !== want.mark_out) begin
        $error("mark_out: expected %b, actual %b", want.mark_out, got.mark_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %b, actual %b", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  bdm_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  bdm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdm_scoreboard grid_sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            cycle_count;
  int            used_rows_now;
  int            used_cols_now;

  binary_disk_morphology_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result transaction; signals are stable at the falling edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) grid_sb.check_result(out_data);
  end

  task automatic send_item(bdm_in_t it);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    grid_sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grid_sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [8:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_sb.write_reg(idx, d);
    used_rows_now = grid_sb.clamp_size(grid_sb.rows_r, DEF_MAX_ROWS);
    used_cols_now = grid_sb.clamp_size(grid_sb.cols_r, DEF_MAX_COLS);
  endtask

  task automatic send_cell(logic [1:0] k, int r, int c, bit m);
    bdm_in_t it;
    it.kind     = k;
    it.cell_row = r[5:0];
    it.cell_col = c[5:0];
    it.mark_in  = m;
    send_item(it);
  endtask

  // Mostly in-grid loads and reads, a few runs, some noise
  task automatic send_random();
    bdm_in_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 48)      it.kind = KIND_LOAD;
    else if (pick < 93) it.kind = KIND_READ;
    else if (pick < 96) it.kind = KIND_RUN;
    else                it.kind = KIND_BAD;
    if ($urandom_range(0, 99) < 88) begin
      it.cell_row = 6'($urandom_range(0, used_rows_now - 1));
      it.cell_col = 6'($urandom_range(0, used_cols_now - 1));
    end else begin
      it.cell_row = 6'($urandom_range(0, 63));
      it.cell_col = 6'($urandom_range(0, 63));
    end
    it.mark_in = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Pick a grid and radius that keeps run time bounded
  task automatic pick_setting();
    int shape, rad;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      write_reg(REG_ROWS, 9'($urandom_range(60, 127)));
      write_reg(REG_COLS, 9'($urandom_range(60, 127)));
      rad = $urandom_range(0, 30) - 15;
    end else if (shape < 3) begin
      write_reg(REG_ROWS, 9'($urandom_range(0, 5)));
      write_reg(REG_COLS, 9'($urandom_range(0, 5)));
      rad = $urandom_range(0, 511) - 256;
    end else begin
      write_reg(REG_ROWS, 9'($urandom_range(1, 12)));
      write_reg(REG_COLS, 9'($urandom_range(1, 12)));
      rad = $urandom_range(0, 126) - 63;
    end
    write_reg(REG_RADIUS, rad[8:0]);
    write_reg(REG_GROW, 9'($urandom_range(0, 1)));
  endtask

  initial begin
    grid_sb        = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    used_rows_now  = DEF_MAX_ROWS;
    used_cols_now  = DEF_MAX_COLS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners of the full grid, unknown kind, default run
    send_cell(KIND_READ, 0, 0, 1'b0);
    send_cell(KIND_LOAD, 0, 0, 1'b1);
    send_cell(KIND_LOAD, 63, 63, 1'b1);
    send_cell(KIND_LOAD, 0, 63, 1'b1);
    send_cell(KIND_READ, 63, 63, 1'b0);
    send_cell(KIND_BAD, 63, 0, 1'b1);
    send_cell(KIND_RUN, 0, 0, 1'b0);
    send_cell(KIND_READ, 1, 1, 1'b0);
    send_cell(KIND_READ, 0, 62, 1'b0);

    // Directed: small grid, out-of-grid addresses, radius below one cell
    write_reg(REG_ROWS, 9'd5);
    write_reg(REG_COLS, 9'd3);
    send_cell(KIND_LOAD, 5, 0, 1'b1);
    send_cell(KIND_READ, 0, 3, 1'b0);
    send_cell(KIND_LOAD, 2, 1, 1'b1);
    write_reg(REG_RADIUS, 9'd15);
    send_cell(KIND_RUN, 0, 0, 1'b0);
    send_cell(KIND_READ, 2, 1, 1'b0);

    // Directed: negative radius swaps mode; saturated and most-negative radius
    write_reg(REG_RADIUS, 9'h1E0);
    write_reg(REG_GROW, 9'd0);
    send_cell(KIND_RUN, 0, 0, 1'b0);
    send_cell(KIND_READ, 2, 2, 1'b0);
    write_reg(REG_RADIUS, 9'd255);
    send_cell(KIND_RUN, 0, 0, 1'b0);
    write_reg(REG_RADIUS, 9'h100);
    write_reg(REG_GROW, 9'd1);
    send_cell(KIND_RUN, 0, 0, 1'b0);
    send_cell(KIND_READ, 4, 2, 1'b0);

    // Directed: clamped grid sizes and ignored register indexes
    write_reg(3'd4, 9'h1FF);
    write_reg(3'd7, 9'h1FF);
    write_reg(REG_ROWS, 9'd0);
    write_reg(REG_COLS, 9'd127);
    send_cell(KIND_LOAD, 0, 63, 1'b1);
    send_cell(KIND_READ, 1, 63, 1'b0);
    send_cell(KIND_READ, 0, 63, 1'b0);

    // Random phases, rotating through the idle patterns
    for (int ph = 0; ph < 17; ph++) begin
      pick_setting();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 5 && n == 50) begin
          // Hold the sender until the block has answered everything
          in_valid <= 1'b0;
          while (grid_sb.pending() > 0) @(posedge clk);
        end
        send_random();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (grid_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bdm_pkg.sv
design/bdm_ctrl.sv
design/bdm_datapath.sv
design/binary_disk_morphology_unit.sv
verif/binary_disk_morphology_unit_tb.sv
